// ----- rtl/core/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 64;
    localparam int unsigned MAX_W   = 32;
    localparam int unsigned EXT_W   = 4;

    localparam logic [MAX_W-1:0] MAX_PAYLOAD_RESET = 32'd1048576;

    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_BINARY = 4'h2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [EXT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [EXT_W-1:0] EXT64_BYTES = 4'd8;

    typedef enum logic [1:0] {
        KIND_CLOSE = 2'd0,
        KIND_PING  = 2'd1,
        KIND_BIN   = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_CLOSE    = 2'd1,
        EV_OVERSIZE = 2'd2
    } t_event;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic [1:0]        frame_class;
        logic              frame_end;
        logic [1:0]        event_res;
        logic              halted;
    } t_result;

endpackage

// ----- rtl/core/wsd_if.sv -----
// ----------------------------------------------------------------------------
// wsd_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [1:0] frame_class;
    logic       frame_end;
    logic [1:0] event_res;
    logic       halted;

    modport source (output valid, output payload_byte, output payload_valid,
                    output frame_class, output frame_end, output event_res,
                    output halted, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input frame_class, input frame_end, input event_res,
                    input halted, output ready);
endinterface

// ----- rtl/core/websocket_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Deframer for unmasked WebSocket server frames, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries the received byte stream, one byte per transfer. For each
//   byte one result leaves on o_res: the payload byte with its valid flag,
//   the frame class, the end-of-frame mark, the halt event and the sticky
//   halted flag.
//   i_cfg_we / i_cfg_wdata write max_payload_bytes; write it only while no
//   byte is in flight.
//   Latency: a result is visible on o_res the cycle after its byte transfer.
//   Throughput: one byte per cycle unless o_res stalls; the frame state
//   machine updates in the cycle it takes a byte, so one may follow each cycle.
//   Stall: while o_res waits, the next byte is still taken if the result
//   leaves in the same cycle; otherwise i_rx.ready drops and the held
//   result stays unchanged.
//   Reset: i_rst_n (synchronous, active low) returns the parser to the
//   first header byte, clears the halt and empties the result register;
//   i_rx.ready stays low while reset is held; max_payload_bytes returns
//   to 1 MiB.
//   A close frame or an oversize length halts parsing until reset; after
//   that every byte yields a result with only halted set.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsd_byte_if.sink    i_rx,
    wsd_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import wsd_pkg::*;

    logic [MAX_W-1:0] r_max_payload;
    logic             space;
    logic             fire;
    logic             res_valid;
    t_result          step_res;
    t_result          held_res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_wdata;
        end
    end

    // take a byte whenever the result register has room and reset is released
    assign i_rx.ready = space && i_rst_n;
    assign fire       = i_rx.valid && space && i_rst_n;

    wsd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_byte        (i_rx.rx_byte),
        .i_max_payload (r_max_payload),
        .o_res         (step_res)
    );

    wsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (step_res),
        .i_ready (o_res.ready),
        .o_space (space),
        .o_valid (res_valid),
        .o_res   (held_res)
    );

    // drive the result channel from the held result
    assign o_res.valid         = res_valid;
    assign o_res.payload_byte  = held_res.payload_byte;
    assign o_res.payload_valid = held_res.payload_valid;
    assign o_res.frame_class   = held_res.frame_class;
    assign o_res.frame_end     = held_res.frame_end;
    assign o_res.event_res     = held_res.event_res;
    assign o_res.halted        = held_res.halted;

endmodule

// ----- rtl/core/wsd_parser.sv -----
// ----------------------------------------------------------------------------
// wsd_parser
// Frame state machine: decodes headers and lengths, tracks payload bytes.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  logic [7:0]                i_byte,
    input  logic [31:0]               i_max_payload,
    output wsd_pkg::t_result          o_res
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_PAY  = 3'd3,
        PH_HALT = 3'd4
    } t_phase;

    t_phase            r_phase, n_phase;
    t_kind             r_kind, n_kind;
    logic [EXT_W-1:0]  r_ext, n_ext;
    logic [LEN_W-1:0]  r_rem, n_rem;

    logic              len_done;
    logic [LEN_W-1:0]  len_val;
    logic [3:0]        opcode;
    logic [6:0]        len7;
    t_result           res;

    assign opcode = i_byte[3:0];
    assign len7   = i_byte[6:0];

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_ext    = r_ext;
        n_rem    = r_rem;
        len_done = 1'b0;
        len_val  = r_rem;
        res      = '0;

        unique case (r_phase)
            PH_HDR0: begin
                priority if (opcode == OP_CLOSE) n_kind = KIND_CLOSE;
                else if (opcode == OP_PING)      n_kind = KIND_PING;
                else if (opcode == OP_BINARY)    n_kind = KIND_BIN;
                else                             n_kind = KIND_OTHER;
                res.frame_class = n_kind;
                n_phase         = PH_HDR1;
            end
            PH_HDR1: begin
                res.frame_class = r_kind;
                n_rem           = '0;
                priority if (len7 == LEN7_EXT16) begin
                    n_ext   = EXT16_BYTES;
                    n_phase = PH_EXT;
                end else if (len7 == LEN7_EXT64) begin
                    n_ext   = EXT64_BYTES;
                    n_phase = PH_EXT;
                end else begin
                    len_val  = {{(LEN_W-7){1'b0}}, len7};
                    n_rem    = len_val;
                    len_done = 1'b1;
                end
            end
            PH_EXT: begin
                // shift in the next big-endian length byte
                res.frame_class = r_kind;
                len_val         = {r_rem[LEN_W-BYTE_W-1:0], i_byte};
                n_rem           = len_val;
                n_ext           = r_ext - 4'd1;
                len_done        = (r_ext == 4'd1);
            end
            PH_PAY: begin
                res.payload_byte  = i_byte;
                res.payload_valid = 1'b1;
                res.frame_class   = r_kind;
                n_rem             = r_rem - 64'd1;
                if (r_rem == 64'd1) begin
                    res.frame_end = 1'b1;
                    n_phase       = PH_HDR0;
                end
            end
            PH_HALT: begin
                res.halted = 1'b1;
            end
            default: begin
                res.halted = 1'b1;
                n_phase    = PH_HALT;
            end
        endcase

        if (len_done) begin
            priority if (r_kind == KIND_CLOSE) begin
                n_phase         = PH_HALT;
                res.event_res   = EV_CLOSE;
                res.halted      = 1'b1;
                res.frame_class = KIND_CLOSE;
            end else if (len_val > {{(LEN_W-MAX_W){1'b0}}, i_max_payload}) begin
                n_phase       = PH_HALT;
                res.event_res = EV_OVERSIZE;
                res.halted    = 1'b1;
            end else if (len_val == '0) begin
                res.frame_end = 1'b1;
                n_phase       = PH_HDR0;
            end else begin
                n_phase = PH_PAY;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_kind  <= KIND_CLOSE;
            r_ext   <= '0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_ext   <= n_ext;
            r_rem   <= n_rem;
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("halt state was left without reset");

    a_pay_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAY |-> r_rem != '0)
        else $error("payload phase with zero remaining length");

    a_ext_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EXT |-> (r_ext != '0 && r_ext <= EXT64_BYTES))
        else $error("extended length counter out of range");

endmodule

// ----- rtl/core/wsd_out_stage.sv -----
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  wsd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_space,
    output logic             o_valid,
    output wsd_pkg::t_result o_res
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // room for a new result when empty or when the held one leaves now
    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- tb/sv/websocket_frame_deframer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top_test
// Streams well-formed frames with random content, headers, length encodings
// and payload limits through the deframer while both channels idle at random.
// Each result is predicted per received byte and matched field by field. The
// run ends on one halting frame, close or oversize, and bytes sent afterwards.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top_test;
    import wsd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_BYTES  = 215;

    // ------------------------------------------------------------------------
    // Per-byte predictor of the frame parser plus the queue of results due.
    // ------------------------------------------------------------------------
    class deframe_tracker;
        typedef enum logic [2:0] {
            ST_HDR0, ST_HDR1, ST_EXT, ST_PAY, ST_HALT
        } t_parse;

        t_parse            st;
        t_kind             kind;
        logic [EXT_W-1:0]  ext_left;
        logic [LEN_W-1:0]  rem;
        logic [MAX_W-1:0]  max_len;
        t_result           due_results[$];
        int                errors;

        function new();
            st       = ST_HDR0;
            kind     = KIND_CLOSE;
            ext_left = '0;
            rem      = '0;
            max_len  = MAX_PAYLOAD_RESET;
            errors   = 0;
        endfunction

        function void set_limit(input logic [MAX_W-1:0] v);
            max_len = v;
        endfunction

        // Length complete: halt on close or oversize, end an empty frame,
        // or move on to the payload.
        function void close_length(inout t_result r);
            if (kind == KIND_CLOSE) begin
                st          = ST_HALT;
                r.event_res = EV_CLOSE;
                r.halted    = 1'b1;
            end else if (rem > {32'b0, max_len}) begin
                st          = ST_HALT;
                r.event_res = EV_OVERSIZE;
                r.halted    = 1'b1;
            end else if (rem == '0) begin
                r.frame_end = 1'b1;
                st          = ST_HDR0;
            end else begin
                st = ST_PAY;
            end
        endfunction

        function void take_byte(input logic [7:0] b);
            t_result r;
            logic [6:0] len7;
            r = '0;
            case (st)
                ST_HDR0: begin
                    if (b[3:0] == OP_CLOSE)       kind = KIND_CLOSE;
                    else if (b[3:0] == OP_PING)   kind = KIND_PING;
                    else if (b[3:0] == OP_BINARY) kind = KIND_BIN;
                    else                          kind = KIND_OTHER;
                    r.frame_class = kind;
                    st = ST_HDR1;
                end
                ST_HDR1: begin
                    r.frame_class = kind;
                    len7 = b[6:0];
                    rem  = '0;
                    if (len7 == LEN7_EXT16) begin
                        ext_left = EXT16_BYTES;
                        st       = ST_EXT;
                    end else if (len7 == LEN7_EXT64) begin
                        ext_left = EXT64_BYTES;
                        st       = ST_EXT;
                    end else begin
                        rem = {57'b0, len7};
                        close_length(r);
                    end
                end
                ST_EXT: begin
                    r.frame_class = kind;
                    rem      = {rem[LEN_W-9:0], b};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == '0) close_length(r);
                end
                ST_PAY: begin
                    r.payload_byte  = b;
                    r.payload_valid = 1'b1;
                    r.frame_class   = kind;
                    rem = rem - 64'd1;
                    if (rem == '0) begin
                        r.frame_end = 1'b1;
                        st          = ST_HDR0;
                    end
                end
                default: begin
                    r.halted = 1'b1;
                end
            endcase
            if (r.halted) r.frame_class = (r.event_res == EV_OVERSIZE) ? kind : KIND_CLOSE;
            due_results = {due_results, r};
        endfunction

        function void cmp_field(input string name, input logic [7:0] e, input logic [7:0] a);
            if (e !== a) begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void match_result(input t_result got);
            t_result e;
            if (due_results.size() == 0) begin
                $error("result with no byte pending: %p", got);
                errors++;
                return;
            end
            e = due_results.pop_front();
            cmp_field("payload_byte",  e.payload_byte,         got.payload_byte);
            cmp_field("payload_valid", {7'b0, e.payload_valid}, {7'b0, got.payload_valid});
            cmp_field("frame_class",   {6'b0, e.frame_class},   {6'b0, got.frame_class});
            cmp_field("frame_end",     {7'b0, e.frame_end},     {7'b0, got.frame_end});
            cmp_field("event_res",     {6'b0, e.event_res},     {6'b0, got.event_res});
            cmp_field("halted",        {7'b0, e.halted},        {7'b0, got.halted});
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    wsd_byte_if rx_ch ();
    wsd_res_if  res_ch ();

    deframe_tracker tracker;
    int             bytes_sent;
    int             cycles;
    bit             calm;      // phase without idling on either side

    websocket_frame_deframer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a transfer never completes.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Gap length: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Result side: stall ready for random stretches, sampled at the rising edge.
    initial begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                res_ch.ready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    // Match every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            tracker.match_result('{res_ch.payload_byte, res_ch.payload_valid,
                                   res_ch.frame_class, res_ch.frame_end,
                                   res_ch.event_res, res_ch.halted});
        end
    end

    // Present one byte, hold it until the transfer, then predict its result.
    // Enter and leave at a falling edge; valid stays high into the next byte
    // unless a gap is drawn.
    task automatic put_byte(input logic [7:0] b);
        int n;
        n = pick_gap();
        if (n > 0) begin
            rx_ch.valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge i_clk); while (!rx_ch.ready);
        tracker.take_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has arrived.
    task automatic drain();
        rx_ch.valid = 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        tracker.set_limit(v);
    endtask

    // Header with random FIN/RSV and mask bits; the length encoding is drawn
    // at random where more than one fits, non-minimal forms included.
    task automatic send_header(input logic [3:0] op, input logic [63:0] len);
        int r;
        int enc;
        logic [6:0] len7;
        r   = $urandom_range(0, 9);
        enc = (r < 6) ? 0 : (r < 8) ? 1 : 2;
        if (len > 64'd65535) enc = 2;
        else if (len > 64'd125 && enc == 0) enc = 1;
        len7 = (enc == 0) ? len[6:0] : (enc == 1) ? LEN7_EXT16 : LEN7_EXT64;
        put_byte({4'($urandom_range(0, 15)), op});
        put_byte({1'($urandom_range(0, 1)), len7});
        if (enc == 1) begin
            put_byte(len[15:8]);
            put_byte(len[7:0]);
        end else if (enc == 2) begin
            for (int i = 7; i >= 0; i--) put_byte(len[i*8 +: 8]);
        end
    endtask

    task automatic send_frame(input logic [3:0] op, input logic [63:0] len);
        send_header(op, len);
        for (longint i = 0; i < longint'(len); i++) put_byte(8'($urandom_range(0, 255)));
    endtask

    // Any opcode but close; ping and binary favored.
    function automatic logic [3:0] pick_op();
        int r;
        logic [3:0] o;
        r = $urandom_range(0, 9);
        if (r < 3) return OP_PING;
        if (r < 6) return OP_BINARY;
        do o = 4'($urandom_range(0, 15)); while (o == OP_CLOSE);
        return o;
    endfunction

    // Payload length within the limit: mostly short, some empty, some exactly
    // at the limit, a few up to a few hundred bytes.
    function automatic logic [63:0] pick_len(input logic [31:0] lim);
        int r;
        int unsigned cap;
        int unsigned wide;
        cap  = (lim < 60) ? lim : 60;
        wide = (lim < 300) ? lim : 300;
        r = $urandom_range(0, 99);
        if (r < 10) return 64'd0;
        if (r < 15 && lim <= 300) return {32'b0, lim};
        if (r < 22) return 64'($urandom_range(0, wide));
        return 64'($urandom_range(0, cap));
    endfunction

    initial begin
        logic [31:0] lim;
        logic [63:0] len;
        int          start;
        int          r;

        tracker       = new();
        bytes_sent    = 0;
        cycles        = 0;
        calm          = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        cfg_we        = 1'b0;
        cfg_wdata     = 32'h0;
        i_rst_n       = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames under the reset limit.
        // Ping, three payload bytes, the byte extremes among them.
        put_byte(8'h89); put_byte(8'h03);
        put_byte(8'h00); put_byte(8'hFF); put_byte(8'h5A);
        // Empty binary frame with the mask bit set: ends on its length byte.
        put_byte(8'h82); put_byte(8'h80);
        // All bits of the first header byte set, opcode 0xF: other class, 16-bit length of 2.
        put_byte(8'hFF); put_byte(8'h7E); put_byte(8'h00); put_byte(8'h02);
        put_byte(8'hA5); put_byte(8'h01);
        // Continuation opcode with a 64-bit length of 1.
        put_byte(8'h00); put_byte(8'h7F);
        repeat (7) put_byte(8'h00);
        put_byte(8'h01); put_byte(8'h80);
        // RSV bits with an empty payload, then a 16-bit length of zero.
        put_byte(8'h70); put_byte(8'h00);
        put_byte(8'h82); put_byte(8'hFE); put_byte(8'h00); put_byte(8'h00);

        // Random frames over a series of limits, extremes included.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: lim = 32'h0;
                1: lim = 32'hFFFF_FFFF;
                2: lim = $urandom_range(1, 40);
                3: lim = $urandom_range(41, 400);
                4: lim = 32'd1;
                default: lim = MAX_PAYLOAD_RESET;
            endcase
            write_limit(lim);
            calm  = ($urandom_range(0, 3) == 0);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) send_frame(pick_op(), pick_len(lim));
        end

        // Halting frame: close or oversize, then bytes that must be ignored.
        drain();
        calm = 1'b0;
        r = $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 0) begin
            // Close carries no size check, so any length is allowed.
            if (r == 0)      len = 64'($urandom_range(0, 125));
            else if (r == 1) len = 64'($urandom_range(126, 65535));
            else             len = {32'($urandom), 32'($urandom)};
            send_header(OP_CLOSE, len);
        end else begin
            lim = $urandom_range(0, 500);
            write_limit(lim);
            if (r == 0) len = {32'b0, lim} + 64'd1 + 64'($urandom_range(0, 3));
            else        len = {32'($urandom) | 32'h1, 32'($urandom)};
            send_header(pick_op(), len);
        end
        repeat (40) put_byte(8'($urandom_range(0, 255)));

        drain();
        if (tracker.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
